// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the color matcher.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define NNCM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NNCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/nncm_pkg.sv =====
package nncm_pkg;

  localparam int unsigned PAL_SIZE  = 18;
  localparam int unsigned PAL_IDX_W = 5;

  localparam logic [15:0] ONE_Q15       = 16'd32768;
  localparam logic [33:0] TINY_NORM_SQ  = 34'd1074;
  localparam logic [31:0] ONE_Q30       = 32'h4000_0000;
  localparam logic [6:0]  FULL_STRENGTH = 7'd100;
  localparam logic [15:0] TOL_RESET     = 16'd328;

  // Named colors in Q1.15, red, green, blue.
  localparam logic [15:0] PAL_RGB [PAL_SIZE][3] = '{
    '{16'd0,     16'd0,     16'd0},
    '{16'd0,     16'd0,     16'd32768},
    '{16'd21201, 16'd5407,  16'd5407},
    '{16'd0,     16'd32768, 16'd32768},
    '{16'd32768, 16'd27623, 16'd0},
    '{16'd24412, 16'd24412, 16'd24412},
    '{16'd0,     16'd32768, 16'd0},
    '{16'd32768, 16'd0,     16'd32768},
    '{16'd32768, 16'd21201, 16'd0},
    '{16'd32768, 16'd24674, 16'd26083},
    '{16'd20546, 16'd4096,  16'd30835},
    '{16'd32768, 16'd0,     16'd0},
    '{16'd15237, 16'd17400, 16'd19595},
    '{16'd9011,  16'd16712, 16'd23134},
    '{16'd14352, 16'd16384, 16'd18448},
    '{16'd17662, 16'd5505,  16'd28934},
    '{16'd32768, 16'd32768, 16'd32768},
    '{16'd32768, 16'd32768, 16'd0}
  };

  // One stored palette entry: unit vector in Q1.30 and length in Q.30.
  typedef struct packed {
    logic [31:0] u0;
    logic [31:0] u1;
    logic [31:0] u2;
    logic [31:0] len;
  } pal_entry_t;

endpackage

// ===== hdl/nncm_if.sv =====
// Input word: one RGBA color.
interface nncm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_level;
  logic [15:0] green_level;
  logic [15:0] blue_level;
  logic [15:0] alpha_level;

  modport source (output valid, red_level, green_level, blue_level, alpha_level,
                  input ready);
  modport sink (input valid, red_level, green_level, blue_level, alpha_level,
                output ready);
endinterface

// Output word: the match result.
interface nncm_out_if;
  logic       valid;
  logic       ready;
  logic       match_found;
  logic [4:0] palette_index;
  logic [6:0] strength_percent;

  modport source (output valid, match_found, palette_index, strength_percent,
                  input ready);
  modport sink (input valid, match_found, palette_index, strength_percent,
                output ready);
endinterface

// ===== hdl/nearest_named_color_match.sv =====
// Nearest named color match. One RGBA word in unsigned Q1.15 goes in and one
// result word comes out: a found flag, the index of the nearest of 18 named
// colors by direction, and the strength in percent (100 is full strength).
// A word whose alpha is off by more than the tolerance gives all zeros. The
// multiplications run on one shared 32x32 multiplier and the square root and
// divide steps on one shared 35-bit subtractor under a sequencer, so the
// block takes one word at a time: in ready is high only while it idles. After
// reset the block first computes the unit vectors and lengths of the palette
// into an 18-entry table, using the same square root and divide steps; no
// word is taken meanwhile (tolerance writes are taken at any time). Alpha off
// tolerance sends a word from idle straight to the result. Otherwise a word
// goes through the squared norm, the square root (two bits a step), the three
// bit-serial divisions of the unit vector, the distance to each palette entry
// and, on a match, the strength division; an input so dark that its squared
// norm is below 1e-6 skips the square root and the unit vector divisions. The
// result is held in an output register until the sink takes it, and the next
// word is taken in the cycle after.
`include "assert_macros.svh"

module nearest_named_color_match (
  input  logic        clk_i,
  input  logic        rst_ni,
  nncm_in_if.sink     in_i,
  nncm_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);
  import nncm_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ     = 4'd1;
  localparam logic [3:0] ST_CHK    = 4'd2;
  localparam logic [3:0] ST_SQRT   = 4'd3;
  localparam logic [3:0] ST_DIVLD  = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_UVDONE = 4'd6;
  localparam logic [3:0] ST_RD     = 4'd7;
  localparam logic [3:0] ST_DIST   = 4'd8;
  localparam logic [3:0] ST_CMP    = 4'd9;
  localparam logic [3:0] ST_STRLD  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam logic [PAL_IDX_W-1:0] LAST_IDX = PAL_IDX_W'(PAL_SIZE - 1);

  logic [3:0]           state_q;
  logic                 init_q;      // palette table is being built
  logic                 str_q;       // divider is busy with the strength
  logic [PAL_IDX_W-1:0] idx_q;
  logic [1:0]           comp_q;
  logic [5:0]           cnt_q;
  logic [15:0]          tol_q;

  logic [15:0] v_q [3];
  logic [31:0] u_q [3];
  logic [31:0] len_q;
  logic [33:0] s_q;

  logic [63:0] sq_x_q;
  logic [32:0] sq_rem_q;
  logic [31:0] sq_root_q;

  logic [63:0] div_n_q;
  logic [31:0] div_rem_q;
  logic [31:0] div_d_q;

  logic [63:0] prod_q;
  logic [63:0] acc_q;
  logic [63:0] best_q;
  logic        found_q;
  logic [PAL_IDX_W-1:0] best_idx_q;
  logic [31:0] best_len_q;

  logic       res_found_q;
  logic [4:0] res_idx_q;
  logic [6:0] res_str_q;

  pal_entry_t pal_mem [PAL_SIZE];
  pal_entry_t rd_q;
  pal_entry_t wr_entry;
  logic       pal_we;

  // Shared multiplier and subtractor.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [34:0] sub_a, sub_b;
  logic [35:0] diff;
  logic        ge;

  logic [32:0] div_t;
  logic [34:0] sq_sh;
  logic [31:0] dcomp;
  logic [16:0] alpha_dev;
  logic [31:0] quot;

  assign div_t = {div_rem_q, div_n_q[63]};
  assign sq_sh = {sq_rem_q, sq_x_q[63:62]};
  assign quot  = {div_n_q[30:0], ge};

  always_comb begin
    logic [31:0] ua, ub;
    ua = 32'd0;
    ub = 32'd0;
    case (comp_q)
      2'd0: begin ua = u_q[0]; ub = rd_q.u0; end
      2'd1: begin ua = u_q[1]; ub = rd_q.u1; end
      2'd2: begin ua = u_q[2]; ub = rd_q.u2; end
      default: begin ua = 32'd0; ub = 32'd0; end
    endcase
    dcomp = (ua >= ub) ? ua - ub : ub - ua;
  end

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state_q)
      ST_SQ: begin
        mul_a = {16'd0, v_q[comp_q]};
        mul_b = {16'd0, v_q[comp_q]};
      end
      ST_DIST: begin
        mul_a = dcomp;
        mul_b = dcomp;
      end
      ST_UVDONE: begin
        mul_a = {16'd0, tol_q};
        mul_b = {16'd0, tol_q};
      end
      ST_STRLD: begin
        mul_a = len_q;
        mul_b = {25'd0, FULL_STRENGTH};
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    if (state_q == ST_SQRT) begin
      sub_a = sq_sh;
      sub_b = {1'b0, sq_root_q, 2'b01};
    end else begin
      sub_a = {2'b0, div_t};
      sub_b = {3'b0, div_d_q};
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = ~diff[35];
  end

  assign alpha_dev = (in_i.alpha_level >= ONE_Q15) ?
                     {1'b0, in_i.alpha_level - ONE_Q15} :
                     {1'b0, ONE_Q15 - in_i.alpha_level};

  assign wr_entry = '{u0: u_q[0], u1: u_q[1], u2: u_q[2], len: len_q};
  assign pal_we   = (state_q == ST_UVDONE) && init_q;

  // Palette table of unit vectors, filled once after reset.
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[idx_q] <= wr_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= pal_mem[idx_q];
  end

  // Tolerance register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_data_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      init_q  <= 1'b1;
      str_q   <= 1'b0;
      idx_q   <= '0;
      comp_q  <= 2'd0;
      cnt_q   <= 6'd0;
      found_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          comp_q <= 2'd0;
          if (init_q) begin
            state_q <= ST_SQ;
          end else if (in_i.valid) begin
            state_q <= (alpha_dev > {1'b0, tol_q}) ? ST_OUT : ST_SQ;
          end
        end
        ST_SQ: begin
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd2) begin
            state_q <= ST_CHK;
          end
        end
        ST_CHK: begin
          comp_q  <= 2'd0;
          cnt_q   <= 6'd31;
          state_q <= (s_q < TINY_NORM_SQ) ? ST_UVDONE : ST_SQRT;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            state_q <= ST_DIVLD;
          end
        end
        ST_DIVLD: begin
          str_q   <= 1'b0;
          cnt_q   <= 6'd63;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            if (str_q) begin
              state_q <= ST_OUT;
            end else if (comp_q == 2'd2) begin
              state_q <= ST_UVDONE;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= ST_DIVLD;
            end
          end
        end
        ST_UVDONE: begin
          if (init_q) begin
            state_q <= ST_IDLE;
            if (idx_q == LAST_IDX) begin
              init_q <= 1'b0;
              idx_q  <= '0;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end else begin
            found_q <= 1'b0;
            idx_q   <= '0;
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          comp_q  <= 2'd0;
          state_q <= ST_DIST;
        end
        ST_DIST: begin
          comp_q <= comp_q + 2'd1;
          if (comp_q == 2'd3) begin
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (acc_q <= best_q) begin
            found_q <= 1'b1;
          end
          if (idx_q == LAST_IDX) begin
            state_q <= ST_STRLD;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_STRLD: begin
          str_q   <= 1'b1;
          cnt_q   <= 6'd63;
          state_q <= found_q ? ST_DIV : ST_OUT;
        end
        ST_OUT: begin
          if (out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        s_q <= '0;
        if (init_q) begin
          v_q[0] <= PAL_RGB[idx_q][0];
          v_q[1] <= PAL_RGB[idx_q][1];
          v_q[2] <= PAL_RGB[idx_q][2];
        end else begin
          v_q[0] <= in_i.red_level;
          v_q[1] <= in_i.green_level;
          v_q[2] <= in_i.blue_level;
        end
        res_found_q <= 1'b0;
        res_idx_q   <= 5'd0;
        res_str_q   <= 7'd0;
      end
      ST_SQ: begin
        s_q <= s_q + mul_p[33:0];
      end
      ST_CHK: begin
        // A near-black vector stays unscaled with unit length.
        u_q[0]    <= {1'b0, v_q[0], 15'd0};
        u_q[1]    <= {1'b0, v_q[1], 15'd0};
        u_q[2]    <= {1'b0, v_q[2], 15'd0};
        len_q     <= ONE_Q30;
        sq_x_q    <= {s_q, 30'd0};
        sq_rem_q  <= '0;
        sq_root_q <= '0;
      end
      ST_SQRT: begin
        sq_x_q    <= {sq_x_q[61:0], 2'b00};
        sq_rem_q  <= ge ? diff[32:0] : sq_sh[32:0];
        sq_root_q <= {sq_root_q[30:0], ge};
        if (cnt_q == 6'd0) begin
          len_q <= {sq_root_q[30:0], ge};
        end
      end
      ST_DIVLD: begin
        div_n_q   <= ({48'd0, v_q[comp_q]} << 45) + {33'd0, len_q[31:1]};
        div_rem_q <= '0;
        div_d_q   <= len_q;
      end
      ST_DIV: begin
        div_n_q   <= {div_n_q[62:0], ge};
        div_rem_q <= ge ? diff[31:0] : div_t[31:0];
        if (cnt_q == 6'd0) begin
          if (str_q) begin
            res_found_q <= 1'b1;
            res_idx_q   <= 5'(best_idx_q);
            res_str_q   <= (quot > 32'(FULL_STRENGTH)) ? FULL_STRENGTH : quot[6:0];
          end else begin
            u_q[comp_q] <= quot;
          end
        end
      end
      ST_UVDONE: begin
        best_q <= {2'b00, mul_p[31:0], 30'd0};
      end
      ST_DIST: begin
        prod_q <= mul_p;
        acc_q  <= (comp_q == 2'd0) ? 64'd0 : acc_q + prod_q;
      end
      ST_CMP: begin
        if (acc_q <= best_q) begin
          best_q     <= acc_q;
          best_idx_q <= idx_q;
          best_len_q <= rd_q.len;
        end
      end
      ST_STRLD: begin
        div_n_q   <= mul_p + {33'd0, best_len_q[31:1]};
        div_rem_q <= '0;
        div_d_q   <= best_len_q;
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready             = (state_q == ST_IDLE) && !init_q;
  assign out_o.valid            = (state_q == ST_OUT);
  assign out_o.match_found      = res_found_q;
  assign out_o.palette_index    = res_idx_q;
  assign out_o.strength_percent = res_str_q;

  // A missing match reports index and strength as zero.
  `NNCM_ASSERT(a_zero_when_none, clk_i, rst_ni,
    !(out_o.valid && !out_o.match_found) ||
    (out_o.palette_index == 5'd0 && out_o.strength_percent == 7'd0),
    "result without a match carries nonzero fields")
  // Strength never exceeds full and the index stays in the palette.
  `NNCM_ASSERT(a_result_range, clk_i, rst_ni,
    !out_o.valid ||
    (out_o.strength_percent <= FULL_STRENGTH && out_o.palette_index <= 5'(LAST_IDX)),
    "result field out of range")
  // The block never takes a word while a result is pending.
  `NNCM_ASSERT(a_one_at_a_time, clk_i, rst_ni, !(in_i.ready && out_o.valid),
    "input ready while a result waits")
  // A taken result returns the block to idle.
  `NNCM_ASSERT_NEXT(a_out_to_idle, clk_i, rst_ni, out_o.valid && out_o.ready,
    !out_o.valid && in_i.ready, "block did not return to idle after a result")

endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import nncm_pkg::*;

  // Three unsigned Q1.15 or Q1.30 components, wide enough for every product
  // that the matcher forms.
  typedef longint unsigned vec3_t [3];

  // One result word as the block should deliver it.
  typedef struct {
    logic       found;
    logic [4:0] index;
    logic [6:0] percent;
  } match_t;

  // Integer square root, floor, of a 64-bit value.
  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // Scales a Q1.15 vector to unit length in Q1.30 and returns its length in
  // Q.30. A vector whose squared norm is below 1e-6 keeps its direction
  // unscaled and counts as length 1.0.
  function automatic longint unsigned scale_to_unit(input vec3_t v, output vec3_t u);
    longint unsigned sq;
    longint unsigned len;
    sq = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (sq < longint'(TINY_NORM_SQ)) begin
      foreach (u[j]) u[j] = v[j] << 15;
      return 64'd1 << 30;
    end
    len = floor_sqrt(sq << 30);
    foreach (u[j]) u[j] = ((v[j] << 45) + (len >> 1)) / len;
    return len;
  endfunction

  class color_match_book;
    longint unsigned tolerance;
    match_t          expected_matches[$];
    int              mismatches;

    function new();
      tolerance = TOL_RESET;
      mismatches = 0;
    endfunction

    // Works out the nearest named color for one RGBA word.
    function match_t nearest_color(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                   logic [15:0] a);
      match_t          m;
      vec3_t           v, u, p, q;
      longint unsigned dev, len_in, len_pal, limit, sq_dist, d, level;
      m = '{found: 1'b0, index: '0, percent: '0};
      dev = (a >= ONE_Q15) ? a - ONE_Q15 : ONE_Q15 - a;
      if (dev > tolerance) return m;
      v[0] = r;
      v[1] = g;
      v[2] = b;
      len_in = scale_to_unit(v, u);
      limit = (tolerance * tolerance) << 30;
      for (int i = 0; i < PAL_SIZE; i++) begin
        foreach (p[j]) p[j] = PAL_RGB[i][j];
        len_pal = scale_to_unit(p, q);
        sq_dist = 0;
        foreach (u[j]) begin
          d = (u[j] >= q[j]) ? u[j] - q[j] : q[j] - u[j];
          sq_dist += d * d;
        end
        // Less-or-equal lets a later entry win a tie.
        if (sq_dist <= limit) begin
          limit = sq_dist;
          level = (100 * len_in + (len_pal >> 1)) / len_pal;
          m.found = 1'b1;
          m.index = 5'(i);
          m.percent = 7'((level > FULL_STRENGTH) ? FULL_STRENGTH : level);
        end
      end
      return m;
    endfunction

    function void note_color(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic [15:0] a);
      expected_matches.push_back(nearest_color(r, g, b, a));
    endfunction

    function void check_match(logic found, logic [4:0] index, logic [6:0] percent);
      match_t e;
      if (expected_matches.size() == 0) begin
        $error("result word with nothing expected");
        mismatches++;
        return;
      end
      e = expected_matches.pop_front();
      if (found !== e.found) begin
        $error("match_found: expected %0d, got %0d", e.found, found);
        mismatches++;
      end
      if (index !== e.index) begin
        $error("palette_index: expected %0d, got %0d", e.index, index);
        mismatches++;
      end
      if (percent !== e.percent) begin
        $error("strength_percent: expected %0d, got %0d", e.percent, percent);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_data_i;

  nncm_in_if  in_bus();
  nncm_out_if out_bus();

  nearest_named_color_match uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_bus),
    .out_o      (out_bus),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  color_match_book book = new();

  // Percent of cycles in which the sender or the receiver holds back.
  int  send_idle_pct;
  int  take_idle_pct;
  // Set at a rising edge where the input word was taken; read by the driver
  // at the next falling edge.
  logic color_taken;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Both channels are watched at the rising edge, where the block's own
  // registers still show their values from before the edge.
  always @(posedge clk_i) begin
    color_taken <= in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready)
      book.note_color(in_bus.red_level, in_bus.green_level, in_bus.blue_level,
                      in_bus.alpha_level);
    if (rst_ni && out_bus.valid && out_bus.ready)
      book.check_match(out_bus.match_found, out_bus.palette_index,
                       out_bus.strength_percent);
  end

  // The receiver stalls at random; the word stays in the block's output
  // register meanwhile.
  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(99) >= take_idle_pct);
  end

  // Hands one color word to the block and returns at the falling edge after
  // it was taken. Idle cycles come first, so a gap can land anywhere in the
  // block's work.
  task automatic send_color(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                            logic [15:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.red_level   <= r;
    in_bus.green_level <= g;
    in_bus.blue_level  <= b;
    in_bus.alpha_level <= a;
    do @(negedge clk_i); while (!color_taken);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (book.expected_matches.size() != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // The block is idle here, so the tolerance may change under it.
  task automatic write_tolerance(logic [15:0] tol);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= tol;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    book.tolerance = tol;
  endtask

  // Random alpha: mostly within the tolerance, sometimes anything at all.
  function automatic logic [15:0] pick_alpha();
    int unsigned span;
    if ($urandom_range(9) == 0) return 16'($urandom_range(16'hFFFF));
    span = (book.tolerance > 32768) ? 32768 : 32'(book.tolerance);
    if ($urandom_range(1)) return 16'(ONE_Q15 - $urandom_range(span));
    return 16'(ONE_Q15 + $urandom_range(span < 32767 ? span : 32767));
  endfunction

  // Most random words are a named color at some brightness with a little
  // noise, so that they land near a palette entry; the rest are anything.
  task automatic send_random_color();
    logic [15:0] c [3];
    int unsigned pick, gain, noise;
    longint      level;
    if ($urandom_range(4) == 0) begin
      foreach (c[j]) c[j] = 16'($urandom_range(16'hFFFF));
    end else begin
      pick  = $urandom_range(PAL_SIZE - 1);
      gain  = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(32768, 1);
      noise = ($urandom_range(1)) ? 0 : (1 << $urandom_range(10));
      foreach (c[j]) begin
        level = (longint'(PAL_RGB[pick][j]) * gain) / 32768
                + longint'($urandom_range(noise)) - longint'(noise / 2);
        c[j] = (level < 0) ? 16'd0 : (level > 65535) ? 16'hFFFF : level[15:0];
      end
    end
    send_color(c[0], c[1], c[2], pick_alpha());
  endtask

  initial begin
    logic [15:0] tol_plan [6];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_data_i         = '0;
    in_bus.valid       = 1'b0;
    in_bus.red_level   = '0;
    in_bus.green_level = '0;
    in_bus.blue_level  = '0;
    in_bus.alpha_level = '0;
    out_bus.ready      = 1'b0;
    send_idle_pct      = 36;
    take_idle_pct      = 65;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words under the reset tolerance. Every named color at full
    // and at half strength, then the corner cases: black, tiny vectors,
    // levels above 1.0, and alpha just inside and just outside the limit.
    for (int i = 0; i < PAL_SIZE; i++) begin
      send_color(PAL_RGB[i][0], PAL_RGB[i][1], PAL_RGB[i][2], ONE_Q15);
      send_color(PAL_RGB[i][0] >> 1, PAL_RGB[i][1] >> 1, PAL_RGB[i][2] >> 1, ONE_Q15);
    end
    send_color(16'd0, 16'd0, 16'd0, ONE_Q15);
    send_color(16'd18, 16'd0, 16'd0, ONE_Q15);
    send_color(16'hFFFF, 16'hFFFF, 16'hFFFF, ONE_Q15);
    send_color(16'h4000, 16'h4000, 16'h4000, ONE_Q15 - TOL_RESET);
    send_color(16'h4000, 16'h4000, 16'h4000, ONE_Q15 + TOL_RESET + 16'd1);
    send_color(16'h8000, 16'h0000, 16'h0000, 16'hFFFF);
    send_color(16'h8000, 16'h0000, 16'h0000, 16'h0000);

    // Each phase sets a tolerance first; the extremes are among them. The
    // idle pattern of the two sides changes after the second and fourth
    // phase.
    tol_plan = '{TOL_RESET, 16'd0, 16'd32768, 16'd3000, 16'd12000,
                 16'($urandom_range(32768))};
    for (int ph = 0; ph < 6; ph++) begin
      drain_results();
      if (ph == 2) begin
        send_idle_pct = 65;
        take_idle_pct = 36;
      end else if (ph == 4) begin
        send_idle_pct = 0;
        take_idle_pct = 0;
      end
      write_tolerance(tol_plan[ph]);
      for (int n = 0; n < 315; n++) begin
        // Once, the sender holds off until every word has come back.
        if (ph == 3 && n == 150) drain_results();
        send_random_color();
      end
    end

    drain_results();
    repeat (500) @(negedge clk_i);
    if (book.mismatches == 0) begin
      $display("** nearest_named_color_match: PASSED **");
    end else begin
      $display("** nearest_named_color_match: FAILED **");
    end
    $finish;
  end

  // About 1900 words plus stalls and the palette setup after reset stay well
  // under this bound.
  initial begin
    #60ms;
    $display("** nearest_named_color_match: FAILED **");
    $finish;
  end

endmodule
